>>> hdl/mcle_pkg.sv
// Package for the MMC command line engine.
// Holds the reply kind codes, register indices, the command and result records and frame constants.
// No dependencies.
`timescale 1ns / 1ps

package mcle_pkg;

    localparam int unsigned HEAD_BITS  = 40;
    localparam int unsigned FRAME_LAST = 47;
    localparam int unsigned R48_LAST   = 46;
    localparam int unsigned R2_SKIP    = 6;
    localparam int unsigned R2_STOP    = 134;
    localparam int unsigned R2_LAST    = 134;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [6:0] CRC7_POLY = 7'h09;
    localparam logic [1:0] HEAD_PFX  = 2'b01;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP      = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_R48  = 2'd1;

    localparam logic [15:0] START_TIMEOUT_RST = 16'd256;
    localparam logic [7:0]  IDLE_GAP_RST      = 8'd8;

    typedef struct packed {
        logic        command;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [1:0]  response_kind;
        logic        line_sample;
    } t_item;

    typedef struct packed {
        logic        drive_level;
        logic        drive_enable;
        logic        engine_busy;
        logic        done_res;
        logic        status;
        logic [31:0] response_word;
        logic        word_valid;
        logic [1:0]  word_number;
    } t_result;

endpackage

>>> hdl/mcle_cmd_if.sv
// Input channel of the MMC command line engine: one word per line tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface mcle_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  response_kind;
    logic        line_sample;

    modport source (output valid, command, cmd_index, argument, response_kind, line_sample,
                    input ready);
    modport sink   (input valid, command, cmd_index, argument, response_kind, line_sample,
                    output ready);
endinterface

>>> hdl/mcle_res_if.sv
// Result channel of the MMC command line engine: one word per line tick.
// Depends on nothing.
`timescale 1ns / 1ps

interface mcle_res_if;
    logic        valid;
    logic        ready;
    logic        drive_level;
    logic        drive_enable;
    logic        engine_busy;
    logic        done_res;
    logic        status;
    logic [31:0] response_word;
    logic        word_valid;
    logic [1:0]  word_number;

    modport source (output valid, drive_level, drive_enable, engine_busy, done_res, status,
                    response_word, word_valid, word_number, input ready);
    modport sink   (input valid, drive_level, drive_enable, engine_busy, done_res, status,
                    response_word, word_valid, word_number, output ready);
endinterface

>>> hdl/mcle_core.sv
// Command line sequencer: frame send with serial CRC-7, reply wait, capture, gap.
// Holds configuration and line state; depends on mcle_pkg.
`timescale 1ns / 1ps

module mcle_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mcle_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mcle_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_take,
    input  mcle_pkg::t_item                    i_item,
    output mcle_pkg::t_result                  o_res
);
    import mcle_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SEND, PH_WAIT, PH_R48, PH_R136, PH_GAP
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [7:0]  r_cnt, n_cnt, e_cnt, inc_cnt;
    logic [39:0] r_frame, n_frame, e_frame;
    logic [6:0]  r_crc, n_crc, e_crc;
    logic [15:0] r_wait, n_wait, inc_wait;
    logic [39:0] r_cap, n_cap, shift_cap;
    logic [1:0]  r_kind, n_kind, e_kind;
    logic        r_to, n_to, e_to;
    logic [15:0] r_timeout;
    logic [7:0]  r_gap;
    logic        issue, fb;
    logic [6:0]  pos;
    t_result     res;

    always_comb begin
        issue     = (r_phase == PH_IDLE) && i_item.command;
        e_phase   = issue ? PH_SEND : r_phase;
        e_frame   = issue ? {HEAD_PFX, i_item.cmd_index, i_item.argument} : r_frame;
        e_crc     = issue ? 7'd0 : r_crc;
        e_cnt     = issue ? 8'd0 : r_cnt;
        e_kind    = issue ? i_item.response_kind : r_kind;
        e_to      = issue ? 1'b0 : r_to;
        inc_cnt   = e_cnt + 8'd1;
        inc_wait  = r_wait + 16'd1;
        shift_cap = {r_cap[38:0], i_item.line_sample};
        pos       = e_cnt[6:0] - 7'(R2_SKIP);
        fb        = 1'b0;

        n_phase = e_phase;
        n_cnt   = e_cnt;
        n_frame = e_frame;
        n_crc   = e_crc;
        n_wait  = r_wait;
        n_cap   = r_cap;
        n_kind  = e_kind;
        n_to    = e_to;

        res               = '0;
        res.drive_level   = 1'b1;
        res.engine_busy   = (e_phase != PH_IDLE);

        case (e_phase)
            PH_SEND: begin
                res.drive_enable = 1'b1;
                n_cnt = inc_cnt;
                if (e_cnt < 8'(HEAD_BITS)) begin
                    res.drive_level = e_frame[39];
                    n_frame = {e_frame[38:0], 1'b1};
                    fb = e_crc[6] ^ e_frame[39];
                    n_crc = {e_crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'd0);
                end else if (e_cnt < 8'(FRAME_LAST)) begin
                    res.drive_level = e_crc[6];
                    n_crc = {e_crc[5:0], 1'b0};
                end
                if (e_cnt == 8'(FRAME_LAST)) begin
                    n_cnt = 8'd0;
                    if (e_kind == KIND_NONE) begin
                        n_phase = (r_gap == 8'd0) ? PH_IDLE : PH_GAP;
                        res.done_res = (r_gap == 8'd0);
                    end else begin
                        n_phase = PH_WAIT;
                        n_wait = 16'd0;
                    end
                end
            end
            PH_WAIT: begin
                if (!i_item.line_sample) begin
                    n_phase = (e_kind == KIND_R48) ? PH_R48 : PH_R136;
                    n_cnt = 8'd0;
                    n_cap = '0;
                end else begin
                    n_wait = inc_wait;
                    if (inc_wait >= r_timeout || inc_wait == 16'd0) begin
                        n_to = 1'b1;
                        n_cnt = 8'd0;
                        n_phase = (r_gap == 8'd0) ? PH_IDLE : PH_GAP;
                        res.done_res = (r_gap == 8'd0);
                    end
                end
            end
            PH_R48: begin
                n_cap = shift_cap;
                n_cnt = inc_cnt;
                if (e_cnt == 8'(R48_LAST)) begin
                    res.response_word = shift_cap[39:8];
                    res.word_valid = 1'b1;
                    n_cnt = 8'd0;
                    n_phase = (r_gap == 8'd0) ? PH_IDLE : PH_GAP;
                    res.done_res = (r_gap == 8'd0);
                end
            end
            PH_R136: begin
                if (e_cnt >= 8'(R2_SKIP) && e_cnt < 8'(R2_STOP)) begin
                    n_cap = shift_cap;
                    if (pos[4:0] == 5'h1F) begin
                        res.response_word = shift_cap[31:0];
                        res.word_valid = 1'b1;
                        res.word_number = pos[6:5];
                    end
                end
                n_cnt = inc_cnt;
                if (e_cnt == 8'(R2_LAST)) begin
                    n_cnt = 8'd0;
                    n_phase = (r_gap == 8'd0) ? PH_IDLE : PH_GAP;
                    res.done_res = (r_gap == 8'd0);
                end
            end
            PH_GAP: begin
                n_cnt = inc_cnt;
                if (inc_cnt >= r_gap || inc_cnt == 8'd0) begin
                    n_phase = PH_IDLE;
                    n_cnt = 8'd0;
                    res.done_res = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        res.status = n_to;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= 8'd0;
            r_wait    <= 16'd0;
            r_kind    <= KIND_NONE;
            r_to      <= 1'b0;
            r_timeout <= START_TIMEOUT_RST;
            r_gap     <= IDLE_GAP_RST;
        end else begin
            if (i_take) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_wait  <= n_wait;
                r_kind  <= n_kind;
                r_to    <= n_to;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_IDLE_GAP:      r_gap <= i_cfg_data[7:0];
                    default:           r_gap <= r_gap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_frame <= n_frame;
            r_crc   <= n_crc;
            r_cap   <= n_cap;
        end
    end

endmodule

>>> hdl/mcle_out_stage.sv
// Result register of the MMC command line engine; parts the two channels.
// Depends on mcle_pkg and mcle_res_if.
`timescale 1ns / 1ps

module mcle_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mcle_pkg::t_result   i_res,
    output logic                o_room,
    mcle_res_if.source          o_res
);
    import mcle_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_room = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.drive_level   = r_data.drive_level;
    assign o_res.drive_enable  = r_data.drive_enable;
    assign o_res.engine_busy   = r_data.engine_busy;
    assign o_res.done_res      = r_data.done_res;
    assign o_res.status        = r_data.status;
    assign o_res.response_word = r_data.response_word;
    assign o_res.word_valid    = r_data.word_valid;
    assign o_res.word_number   = r_data.word_number;

endmodule

>>> hdl/mmc_command_line_engine_unit.sv
// Top level of the MMC command line engine.
// Depends on mcle_pkg, mcle_cmd_if, mcle_res_if, mcle_core and mcle_out_stage.
//
//   port      dir   word                              handshake
//   i_cmd     in    command, index, argument, kind,   valid / ready
//                   line sample (one line tick)
//   o_res     out   drive, busy, done, status, reply  valid / ready
//   i_cfg_*   in    register index, data              write enable only
//
// One word in, one word out; a new word is taken every cycle while the result register has room.
// The result comes out of the result register in the cycle after its word is taken.
// A stalled result register holds the input off; no word is dropped.
// Synchronous reset loads the idle state and the default timeout and gap.
`timescale 1ns / 1ps

module mmc_command_line_engine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mcle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mcle_cmd_if.sink                          i_cmd,
    mcle_res_if.source                        o_res
);
    import mcle_pkg::*;

    logic    room, take;
    t_item   item;
    t_result res;

    assign i_cmd.ready = room;
    assign take        = i_cmd.valid && room;

    assign item.command       = i_cmd.command;
    assign item.cmd_index     = i_cmd.cmd_index;
    assign item.argument      = i_cmd.argument;
    assign item.response_kind = i_cmd.response_kind;
    assign item.line_sample   = i_cmd.line_sample;

    mcle_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_item     (item),
        .o_res      (res)
    );

    mcle_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (res),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

>>> test/mcle_line_checker.sv
// Checker for the MMC command line engine: predicts one result word per line tick.
// Watches the command, result and register ports; depends on mcle_pkg,
// mcle_cmd_if and mcle_res_if.
`timescale 1ns / 1ps

module mcle_line_checker
    import mcle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcle_cmd_if                   i_cmd,
    mcle_res_if                   i_res,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int FRAME_BITS = 48;
    localparam int R48_BITS   = 47;
    localparam int REPLY_SKIP = 6;
    localparam int REPLY_STOP = 134;
    localparam int REPLY_END  = 135;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_SEND,
        LN_WAIT,
        LN_R48,
        LN_R136,
        LN_GAP
    } t_line_phase;

    t_line_phase line_phase;
    logic [7:0]  tick_cnt;
    logic [47:0] frame_bits;
    logic [15:0] wait_cnt;
    logic [47:0] reply_bits;
    logic [1:0]  reply_sel;
    logic        timeout_flag;
    logic [15:0] timeout_reg;
    logic [7:0]  gap_reg;

    t_result     predicted_line_states[$];
    t_item       seen_item;
    t_result     seen_res;
    t_result     want;
    int          res_seen;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        res_seen  = 0;
    end

    function automatic logic [6:0] crc7_over(input logic [39:0] bits);
        logic [6:0] crc;
        logic       fb;
        crc = '0;
        for (int i = 39; i >= 0; i--) begin
            fb  = crc[6] ^ bits[i];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC7_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic close_command();
        tick_cnt = '0;
        if (gap_reg == 8'd0) begin
            line_phase = LN_IDLE;
            return 1'b1;
        end
        line_phase = LN_GAP;
        return 1'b0;
    endfunction

    function automatic t_result advance_line(input t_item it);
        t_result     r;
        logic [39:0] head;
        logic [7:0]  pos;
        r = '0;
        r.drive_level = 1'b1;
        if (line_phase == LN_IDLE && it.command) begin
            head         = {HEAD_PFX, it.cmd_index, it.argument};
            frame_bits   = {head, crc7_over(head), 1'b1};
            reply_sel    = it.response_kind;
            timeout_flag = 1'b0;
            tick_cnt     = '0;
            line_phase   = LN_SEND;
        end
        r.engine_busy = (line_phase != LN_IDLE);
        case (line_phase)
            LN_SEND: begin
                r.drive_enable = 1'b1;
                r.drive_level  = frame_bits[47];
                frame_bits     = {frame_bits[46:0], 1'b1};
                tick_cnt++;
                if (tick_cnt >= 8'(FRAME_BITS)) begin
                    tick_cnt = '0;
                    if (reply_sel == KIND_NONE) begin
                        r.done_res = close_command();
                    end else begin
                        line_phase = LN_WAIT;
                        wait_cnt   = '0;
                    end
                end
            end
            LN_WAIT: begin
                if (!it.line_sample) begin
                    line_phase = (reply_sel == KIND_R48) ? LN_R48 : LN_R136;
                    tick_cnt   = '0;
                    reply_bits = '0;
                end else begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= timeout_reg || wait_cnt == 16'd0) begin
                        timeout_flag = 1'b1;
                        r.done_res   = close_command();
                    end
                end
            end
            LN_R48: begin
                reply_bits = {reply_bits[46:0], it.line_sample};
                tick_cnt++;
                if (tick_cnt >= 8'(R48_BITS)) begin
                    r.response_word = reply_bits[39:8];
                    r.word_valid    = 1'b1;
                    r.done_res      = close_command();
                end
            end
            LN_R136: begin
                if (tick_cnt >= 8'(REPLY_SKIP) && tick_cnt < 8'(REPLY_STOP)) begin
                    pos        = tick_cnt - 8'(REPLY_SKIP);
                    reply_bits = {reply_bits[46:0], it.line_sample};
                    if (pos[4:0] == 5'd31) begin
                        r.response_word = reply_bits[31:0];
                        r.word_valid    = 1'b1;
                        r.word_number   = pos[6:5];
                    end
                end
                tick_cnt++;
                if (tick_cnt >= 8'(REPLY_END)) begin
                    r.done_res = close_command();
                end
            end
            LN_GAP: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= gap_reg || tick_cnt == 8'd0) begin
                    line_phase = LN_IDLE;
                    tick_cnt   = '0;
                    r.done_res = 1'b1;
                end
            end
            default: begin
                line_phase = LN_IDLE;
            end
        endcase
        r.status = timeout_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        o_errors++;
        if (o_errors <= 40) begin
            $display("  mismatch at result word %0d: %s", res_seen, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_phase   = LN_IDLE;
            tick_cnt     = '0;
            frame_bits   = '1;
            wait_cnt     = '0;
            reply_bits   = '0;
            reply_sel    = KIND_NONE;
            timeout_flag = 1'b0;
            timeout_reg  = START_TIMEOUT_RST;
            gap_reg      = IDLE_GAP_RST;
            predicted_line_states.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_TIMEOUT: timeout_reg = i_cfg_data;
                    CFG_IDLE_GAP:      gap_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                seen_item.command       = i_cmd.command;
                seen_item.cmd_index     = i_cmd.cmd_index;
                seen_item.argument      = i_cmd.argument;
                seen_item.response_kind = i_cmd.response_kind;
                seen_item.line_sample   = i_cmd.line_sample;
                predicted_line_states.push_back(advance_line(seen_item));
            end
            if (i_res.valid && i_res.ready) begin
                seen_res.drive_level   = i_res.drive_level;
                seen_res.drive_enable  = i_res.drive_enable;
                seen_res.engine_busy   = i_res.engine_busy;
                seen_res.done_res      = i_res.done_res;
                seen_res.status        = i_res.status;
                seen_res.response_word = i_res.response_word;
                seen_res.word_valid    = i_res.word_valid;
                seen_res.word_number   = i_res.word_number;
                if (predicted_line_states.size() == 0) begin
                    report_mismatch("result word with no input word behind it");
                end else begin
                    want = predicted_line_states.pop_front();
                    check_field("drive_level", 32'(seen_res.drive_level),
                                32'(want.drive_level));
                    check_field("drive_enable", 32'(seen_res.drive_enable),
                                32'(want.drive_enable));
                    check_field("engine_busy", 32'(seen_res.engine_busy),
                                32'(want.engine_busy));
                    check_field("done_res", 32'(seen_res.done_res), 32'(want.done_res));
                    check_field("status", 32'(seen_res.status), 32'(want.status));
                    check_field("response_word", seen_res.response_word, want.response_word);
                    check_field("word_valid", 32'(seen_res.word_valid),
                                32'(want.word_valid));
                    check_field("word_number", 32'(seen_res.word_number),
                                32'(want.word_number));
                end
                res_seen++;
            end
        end
        o_pending = predicted_line_states.size();
    end

endmodule

>>> test/tb_mmc_command_line_engine_unit.sv
// Testbench top for the MMC command line engine: drives command frames, device
// replies, timeouts and register changes under varying flow control.
// Depends on mcle_pkg, both channel interfaces, the engine and mcle_line_checker.
`timescale 1ns / 1ps

module tb_mmc_command_line_engine_unit;
    import mcle_pkg::*;

    localparam int         RUN_LIMIT = 400000;
    localparam int         HOLD_LEN  = 300;
    localparam logic [1:0] KIND_R136 = 2'd2;
    localparam logic [1:0] KIND_ODD  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcle_cmd_if cmd_bus();
    mcle_res_if res_bus();

    int          chk_pending;
    int          chk_errors;
    int          cycle_count;
    int          sender_gap_pct;
    int          sink_stall_pct;
    int          hold_asked;
    int          hold_seen;
    int          hold_left;
    int          words_sent;
    int          cmd_total;
    int          timeout_total;
    int          kind_tally[4];
    logic [15:0] timeout_now;
    logic [7:0]  gap_now;

    mmc_command_line_engine_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    mcle_line_checker line_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .i_res      (res_bus),
        .o_pending  (chk_pending),
        .o_errors   (chk_errors)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("run stopped at the cycle limit, %0d results outstanding", chk_pending);
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic put_word(input logic cmd, input logic [5:0] idx, input logic [31:0] arg,
                            input logic [1:0] kind, input logic line);
        @(negedge i_clk);
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= cmd;
        cmd_bus.cmd_index     <= idx;
        cmd_bus.argument      <= arg;
        cmd_bus.response_kind <= kind;
        cmd_bus.line_sample   <= line;
        words_sent++;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    // stray issues; the engine ignores any that land while it is busy
    task automatic busy_tick(input logic line);
        put_word($urandom_range(7) == 0, 6'($urandom_range(63)), $urandom,
                 2'($urandom_range(3)), line);
    endtask

    task automatic quiet_tick();
        put_word(1'b0, 6'($urandom_range(63)), $urandom, 2'($urandom_range(3)),
                 1'($urandom_range(1)));
    endtask

    task automatic drain();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_START_TIMEOUT) begin
            timeout_now = data;
        end else begin
            gap_now = data[7:0];
        end
    endtask

    // delay: high ticks before the start bit; at or past the timeout (at least one when it is zero), no start bit
    task automatic run_command(input logic [5:0] idx, input logic [31:0] arg,
                               input logic [1:0] kind, input int delay);
        int limit;
        limit = (timeout_now == 16'd0) ? 1 : int'(timeout_now);
        put_word(1'b1, idx, arg, kind, 1'($urandom_range(1)));
        repeat (47) busy_tick(1'($urandom_range(1)));
        if (kind != KIND_NONE) begin
            if (delay >= limit) begin
                repeat (limit) busy_tick(1'b1);
                timeout_total++;
            end else begin
                repeat (delay) busy_tick(1'b1);
                busy_tick(1'b0);
                repeat ((kind == KIND_R48) ? 47 : 135) busy_tick(1'($urandom_range(1)));
            end
        end
        repeat (gap_now) quiet_tick();
        cmd_total++;
        kind_tally[kind]++;
    endtask

    // retune the idle gap while a command sits in its gap
    task automatic gap_retune(input int ticks_in, input logic [7:0] new_gap);
        drain();
        set_reg(CFG_IDLE_GAP, 16'd200);
        put_word(1'b1, 6'($urandom_range(63)), $urandom, KIND_NONE, 1'b1);
        repeat (47) busy_tick(1'($urandom_range(1)));
        repeat (ticks_in) quiet_tick();
        drain();
        set_reg(CFG_IDLE_GAP, {8'h00, new_gap});
        repeat (((new_gap > ticks_in) ? new_gap - ticks_in : 1) + 3) quiet_tick();
        cmd_total++;
        kind_tally[KIND_NONE]++;
    endtask

    initial begin
        int          phase_start;
        int          n_cmd;
        int          limit;
        int          delay;
        logic [15:0] t_pick;
        logic [7:0]  g_pick;

        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = 1'b0;
        cmd_bus.cmd_index     = '0;
        cmd_bus.argument      = '0;
        cmd_bus.response_kind = KIND_NONE;
        cmd_bus.line_sample   = 1'b1;
        res_bus.ready         = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_START_TIMEOUT;
        cfg_data              = '0;
        i_rst_n               = 1'b0;
        timeout_now           = START_TIMEOUT_RST;
        gap_now               = IDLE_GAP_RST;
        sender_gap_pct        = 0;
        sink_stall_pct        = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        repeat (3) quiet_tick();
        run_command(6'd0, 32'h0000_0000, KIND_NONE, 0);
        run_command(6'd2, 32'h5555_AAAA, KIND_ODD, 1);
        drain();
        set_reg(CFG_START_TIMEOUT, 16'd20);
        run_command(6'd13, 32'h0001_0000, KIND_R48, 20);
        run_command(6'd9, 32'h1234_5678, KIND_R48, 19);
        hold_asked++;
        run_command(6'd2, $urandom, KIND_NONE, 0);
        gap_retune(12, 8'd6);
        drain();
        set_reg(CFG_START_TIMEOUT, 16'd0);
        set_reg(CFG_IDLE_GAP, 16'd0);
        run_command(6'd55, $urandom, KIND_R48, 1);
        run_command(6'd8, $urandom, KIND_R48, 0);
        run_command(6'd42, $urandom, KIND_NONE, 0);
        drain();
        set_reg(CFG_START_TIMEOUT, 16'd1);
        set_reg(CFG_IDLE_GAP, 16'hFF03);
        run_command(6'd63, 32'hFFFF_FFFF, KIND_R48, 0);
        run_command(6'd41, $urandom, KIND_R48, 1);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_gap_pct = 84; sink_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  sink_stall_pct = 84; end
                default: begin sender_gap_pct = 9; sink_stall_pct = 9; end
            endcase
            if (ph == 0 || ph == 3) begin
                hold_asked++;
            end
            phase_start = words_sent;
            n_cmd = 0;
            while (words_sent - phase_start < 60) begin
                if (n_cmd % 3 == 0) begin
                    drain();
                    case ($urandom_range(5))
                        0:       t_pick = 16'd0;
                        1:       t_pick = 16'd1;
                        2:       t_pick = 16'hFFFF;
                        3:       t_pick = 16'($urandom);
                        default: t_pick = 16'($urandom_range(300, 2));
                    endcase
                    g_pick = ($urandom_range(15) == 0) ? 8'd255 : 8'($urandom_range(10));
                    set_reg(CFG_START_TIMEOUT, t_pick);
                    set_reg(CFG_IDLE_GAP, {8'($urandom_range(255)), g_pick});
                end
                n_cmd++;
                case ($urandom_range(19))
                    0: begin
                        // broken sequence: random ticks right after an issue, then flush
                        put_word(1'b1, 6'($urandom_range(63)), $urandom,
                                 2'($urandom_range(3)), 1'($urandom_range(1)));
                        repeat ($urandom_range(60)) begin
                            busy_tick(1'($urandom_range(1)));
                        end
                        repeat (220 + gap_now) quiet_tick();
                    end
                    1: begin
                        repeat ($urandom_range(4, 1)) quiet_tick();
                    end
                    default: begin
                        limit = (timeout_now == 16'd0) ? 1 : int'(timeout_now);
                        delay = $urandom_range((limit > 12) ? 12 : limit - 1);
                        if (limit <= 300 && $urandom_range(5) == 0) begin
                            delay = limit;
                        end else if (limit <= 300 && $urandom_range(9) == 0) begin
                            delay = limit - 1;
                        end
                        run_command(6'($urandom_range(63)), $urandom, 2'($urandom_range(3)),
                                    delay);
                    end
                endcase
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("covered %0d input words, %0d commands (none %0d, R48 %0d, R136 %0d, kind 3 %0d)",
                 words_sent, cmd_total, kind_tally[0], kind_tally[1], kind_tally[2],
                 kind_tally[3]);
        $display("%0d start-bit timeouts driven, %0d mismatches seen", timeout_total, chk_errors);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
